// File: design/sqwf_pkg.sv
`timescale 1ns / 1ps

package sqwf_pkg;

    localparam int WINDOW_DEF    = 64;
    localparam int NUM_PEERS_DEF = 16;

    localparam int SEQ_W    = 32;
    localparam int PEER_W   = 4;
    localparam int STATUS_W = 2;
    localparam int CFG_W    = 5;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;
    localparam int Q_DEPTH  = 2;

    localparam logic [CFG_W-1:0] ACTIVE_PEERS_RESET = 5'd16;

    // register index, taken from the word address
    localparam logic [APB_AW-3:0] REG_ACTIVE_PEERS = '0;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DUP     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVERRUN = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BADPEER = 2'd3;

    typedef struct packed {
        logic              req;
        logic [PEER_W-1:0] peer;
        logic [SEQ_W-1:0]  seq;
        logic              bad;
    } t_item;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EVAL,
        S_COUNT,
        S_ADV,
        S_SHIFT,
        S_DONE
    } t_back_state;

endpackage

// File: design/sqwf_ram.sv
`timescale 1ns / 1ps

module sqwf_ram #(
    parameter  int WIDTH = 32,
    parameter  int DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: design/sqwf_front.sv
`timescale 1ns / 1ps

module sqwf_front #(
    parameter int NUM_PEERS = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic                        i_req_type,
    input  logic [sqwf_pkg::PEER_W-1:0] i_peer,
    input  logic [sqwf_pkg::SEQ_W-1:0]  i_seq_number,
    input  logic [sqwf_pkg::CFG_W-1:0]  i_active_peers,
    output logic                        o_push,
    output sqwf_pkg::t_item             o_push_data,
    input  logic                        i_full
);

    import sqwf_pkg::*;

    logic  r_valid;
    t_item r_item;
    logic  accept;
    logic  bad;

    // peer is rejected when beyond the configured count or the storage
    assign bad = ({1'b0, i_peer} >= i_active_peers) || (32'(i_peer) >= NUM_PEERS);

    assign o_stall = r_valid && i_full;
    assign accept  = i_valid && !o_stall;
    assign o_push  = r_valid && !i_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_valid     <= 1'b1;
                r_item.req  <= i_req_type;
                r_item.peer <= i_peer;
                r_item.seq  <= i_seq_number;
                r_item.bad  <= bad;
            end else if (o_push) begin
                r_valid <= 1'b0;
            end
        end
    end

    assign o_push_data = r_item;

endmodule

// File: design/sqwf_queue.sv
`timescale 1ns / 1ps

module sqwf_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  sqwf_pkg::t_item i_push_data,
    output logic            o_full,
    input  logic            i_pop,
    output sqwf_pkg::t_item o_pop_data,
    output logic            o_empty
);

    import sqwf_pkg::*;

    localparam int QAW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;

    t_item          r_slot [Q_DEPTH];
    logic [QAW-1:0] r_wr_ptr;
    logic [QAW-1:0] r_rd_ptr;
    logic [QAW:0]   r_count;
    logic           do_push;
    logic           do_pop;

    assign o_full  = (r_count == (QAW + 1)'(Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_slot[r_wr_ptr] <= i_push_data;
                r_wr_ptr <= (r_wr_ptr == QAW'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == QAW'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_pop_data = r_slot[r_rd_ptr];

endmodule

// File: design/sqwf_back.sv
`timescale 1ns / 1ps

module sqwf_back #(
    parameter int WINDOW    = 64,
    parameter int NUM_PEERS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_q_empty,
    input  sqwf_pkg::t_item               i_q_data,
    output logic                          o_q_pop,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [sqwf_pkg::STATUS_W-1:0] o_status,
    output logic [sqwf_pkg::SEQ_W-1:0]    o_window_base
);

    import sqwf_pkg::*;

    localparam int AW = (NUM_PEERS > 1) ? $clog2(NUM_PEERS) : 1;
    localparam int CW = $clog2(WINDOW + 1);

    t_back_state         r_state;
    t_back_state         n_state;
    t_item               r_item;
    logic                r_ent_vld;
    logic [NUM_PEERS-1:0] r_vld;
    logic [STATUS_W-1:0] r_status;
    logic [SEQ_W-1:0]    r_base;
    logic [WINDOW-1:0]   r_map;
    logic                r_upd;
    logic [CW-1:0]       r_run;
    logic [SEQ_W-1:0]    r_new_base;
    logic [CW-1:0]       r_shamt;
    logic                r_out_valid;
    logic [STATUS_W-1:0] r_out_status;
    logic [SEQ_W-1:0]    r_out_base;

    logic [SEQ_W-1:0]    base_rdata;
    logic [WINDOW-1:0]   map_rdata;
    logic [SEQ_W-1:0]    base_rd;
    logic [WINDOW-1:0]   map_rd;
    logic [SEQ_W:0]      diff;
    logic [WINDOW-1:0]   mask;
    logic [WINDOW-1:0]   map_set;
    logic                hit;
    logic [STATUS_W-1:0] status;
    logic                upd;
    logic                at_base;
    logic [WINDOW-1:0]   map_inc;
    logic [WINDOW-1:0]   first_zero;
    logic [CW-1:0]       run;
    logic [SEQ_W:0]      sum;
    logic [AW-1:0]       rd_addr;
    logic [AW-1:0]       wr_addr;
    logic                rd_en;
    logic                wr_en;
    logic [SEQ_W-1:0]    base_wdata;
    logic [WINDOW-1:0]   map_wdata;
    logic                out_free;
    logic                out_load;

    function automatic logic [CW-1:0] f_onehot_index(input logic [WINDOW-1:0] v);
        logic [CW-1:0] idx;
        idx = '0;
        for (int i = 0; i < WINDOW; i++) begin
            if (v[i]) begin
                idx = idx | CW'(i);
            end
        end
        return idx;
    endfunction

    assign rd_addr = AW'(i_q_data.peer);
    assign wr_addr = AW'(r_item.peer);

    sqwf_ram #(
        .WIDTH (SEQ_W),
        .DEPTH (NUM_PEERS)
    ) u_base_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (base_wdata),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (base_rdata)
    );

    sqwf_ram #(
        .WIDTH (WINDOW),
        .DEPTH (NUM_PEERS)
    ) u_map_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (map_wdata),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (map_rdata)
    );

    // an entry never written reads as the reset state
    assign base_rd = r_ent_vld ? base_rdata : '0;
    assign map_rd  = r_ent_vld ? map_rdata  : '0;

    // the map is held relative to the base: bit i marks base + i
    always_comb begin
        diff    = {1'b0, r_item.seq} - {1'b0, base_rd};
        mask    = WINDOW'(1) << diff[CW-1:0];
        map_set = map_rd | mask;
        hit     = |(map_rd & mask);
        if (diff[SEQ_W]) begin
            status = ST_DUP;
        end else if (diff[SEQ_W-1:0] >= SEQ_W'(WINDOW)) begin
            status = ST_OVERRUN;
        end else if (hit) begin
            status = ST_DUP;
        end else begin
            status = ST_OK;
        end
        upd     = (status == ST_OK) && r_item.req;
        at_base = (diff[SEQ_W-1:0] == '0);
    end

    // length of the run of set bits from the base
    always_comb begin
        map_inc    = r_map + 1'b1;
        first_zero = ~r_map & map_inc;
        run        = (&r_map) ? CW'(WINDOW) : f_onehot_index(first_zero);
    end

    assign sum      = {1'b0, r_base} + (SEQ_W + 1)'(r_run);
    assign out_free = !r_out_valid || !i_stall;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (!i_q_empty) begin
                    n_state = i_q_data.bad ? S_DONE : S_EVAL;
                end
            end
            S_EVAL: begin
                n_state = (upd && at_base) ? S_COUNT : S_DONE;
            end
            S_COUNT: n_state = S_ADV;
            S_ADV:   n_state = S_SHIFT;
            S_SHIFT: n_state = S_DONE;
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_q_pop    = 1'b0;
        rd_en      = 1'b0;
        wr_en      = 1'b0;
        base_wdata = base_rd;
        map_wdata  = map_set;
        out_load   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_q_pop = !i_q_empty;
                rd_en   = !i_q_empty;
            end
            S_EVAL: begin
                wr_en = upd && !at_base;
            end
            S_SHIFT: begin
                wr_en      = 1'b1;
                base_wdata = r_new_base;
                map_wdata  = r_map >> r_shamt;
            end
            S_DONE: begin
                out_load = out_free;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (wr_en) begin
                r_vld[wr_addr] <= 1'b1;
            end
            if (o_q_pop) begin
                r_item    <= i_q_data;
                r_ent_vld <= r_vld[rd_addr];
                r_status  <= ST_BADPEER;
                r_base    <= '0;
            end
            if (r_state == S_EVAL) begin
                r_status <= status;
                r_base   <= base_rd;
                r_map    <= map_set;
                r_upd    <= upd;
            end
            if (r_state == S_COUNT) begin
                r_run <= run;
            end
            // stop at the top of the number space and keep its bit
            if (r_state == S_ADV) begin
                if (sum[SEQ_W]) begin
                    r_new_base <= '1;
                    r_shamt    <= CW'(~r_base);
                end else begin
                    r_new_base <= sum[SEQ_W-1:0];
                    r_shamt    <= r_run;
                end
            end
            if (r_state == S_SHIFT) begin
                r_base <= r_new_base;
            end
            if (out_load) begin
                r_out_valid  <= 1'b1;
                r_out_status <= r_status;
                r_out_base   <= r_base;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_out_status;
    assign o_window_base = r_out_base;

    a_shift_only_on_register: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SHIFT) |-> r_upd)
        else $error("base advance without a register request");

    a_run_starts_at_base: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_COUNT) |-> r_map[0])
        else $error("base bit clear when counting the run");

    a_bad_peer_base_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status == ST_BADPEER)) |-> (r_out_base == '0))
        else $error("bad peer result carries a non-zero base");

endmodule

// File: design/seqno_window_duplicate_filter.sv
`timescale 1ns / 1ps

// Per-peer sliding receive window for duplicate detection. Each transaction
// names a peer and a sequence number and returns one result: ok, duplicate,
// window overrun or bad peer, with the peer's lowest unreceived number after
// the transaction (zero for a bad peer). A register request with status ok
// marks the number, and when it equals the base the base moves past the run
// of received numbers. A front stage accepts and checks the peer against
// active_peers and the peer storage; a short queue decouples it from the
// back end, which does a read-modify-write of the peer's entry in two RAMs
// with a read and a write port, one transaction at a time. A bad peer is
// not written; a register at the base also counts the run, adds it to the
// base and shifts the map. Both stores read as cleared after reset through
// per-peer valid bits; there is no clearing pass.
module seqno_window_duplicate_filter #(
    parameter int WINDOW    = sqwf_pkg::WINDOW_DEF,
    parameter int NUM_PEERS = sqwf_pkg::NUM_PEERS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic                          i_req_type,
    input  logic [sqwf_pkg::PEER_W-1:0]   i_peer,
    input  logic [sqwf_pkg::SEQ_W-1:0]    i_seq_number,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic [sqwf_pkg::STATUS_W-1:0] o_status,
    output logic [sqwf_pkg::SEQ_W-1:0]    o_window_base,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [sqwf_pkg::APB_AW-1:0]   paddr,
    input  logic [sqwf_pkg::APB_DW-1:0]   pwdata,
    output logic [sqwf_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);

    import sqwf_pkg::*;

    logic [CFG_W-1:0] r_active_peers;
    logic             cfg_wr;
    logic             sel_active;
    logic             q_push;
    t_item            q_push_data;
    logic             q_full;
    logic             q_pop;
    t_item            q_pop_data;
    logic             q_empty;

    assign pready     = 1'b1;
    assign sel_active = (paddr[APB_AW-1:2] == REG_ACTIVE_PEERS);
    assign cfg_wr     = psel && penable && pwrite && pready;
    assign prdata     = sel_active ? APB_DW'(r_active_peers) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_peers <= ACTIVE_PEERS_RESET;
        end else if (cfg_wr && sel_active) begin
            r_active_peers <= pwdata[CFG_W-1:0];
        end
    end

    sqwf_front #(
        .NUM_PEERS (NUM_PEERS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_req_type     (i_req_type),
        .i_peer         (i_peer),
        .i_seq_number   (i_seq_number),
        .i_active_peers (r_active_peers),
        .o_push         (q_push),
        .o_push_data    (q_push_data),
        .i_full         (q_full)
    );

    sqwf_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (q_push),
        .i_push_data (q_push_data),
        .o_full      (q_full),
        .i_pop       (q_pop),
        .o_pop_data  (q_pop_data),
        .o_empty     (q_empty)
    );

    sqwf_back #(
        .WINDOW    (WINDOW),
        .NUM_PEERS (NUM_PEERS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_empty     (q_empty),
        .i_q_data      (q_pop_data),
        .o_q_pop       (q_pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_status      (o_status),
        .o_window_base (o_window_base)
    );

endmodule
